// File: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes of the double-ended queue: request and status codes,
// the decoded command and the back-end state encoding.
// ----------------------------------------------------------------------------
package dq_pkg;

    // request codes as they arrive on req_type
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_SEARCH     = 3'd4;
    localparam logic [2:0] REQ_CLEAR      = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SEARCH,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic push;
        logic pop;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_OUT
    } bk_state_t;

endpackage

// File: rtl/core/double_ended_queue_with_search_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_core
// Bounded double-ended queue with value search over a ring store.
// ----------------------------------------------------------------------------
// A request enters a two-entry command queue and is carried out by the back
// end, so a new request is taken while an earlier result waits on out_stall.
// Push, remove, clear and unused codes update the pointers, write the store
// and fetch both ends, then load the result register. A search on an empty
// store goes straight to the result; otherwise it stops at the first match or
// after all entries held. The scan reads one entry per cycle through one of
// the two store read ports. Results come out in request order, one per request.
module double_ended_queue_with_search_core #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [4:0] occupancy,
    output logic       is_empty,
    output logic [7:0] front_value,
    output logic [7:0] back_value,
    output logic [3:0] found_position
);
    import dq_pkg::*;

    logic                  cmd_valid;
    logic                  cmd_pop;
    cmd_t                  cmd;
    logic [DATA_WIDTH-1:0] cmd_data;

    dq_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_data  (cmd_data),
        .cmd_pop   (cmd_pop)
    );

    dq_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_data       (cmd_data),
        .cmd_pop        (cmd_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .occupancy      (occupancy),
        .is_empty       (is_empty),
        .front_value    (front_value),
        .back_value     (back_value),
        .found_position (found_position)
    );

endmodule

// File: rtl/core/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front
// Takes requests, decodes them into commands and holds them in a two-entry
// queue that the execution side drains.
// ----------------------------------------------------------------------------
module dq_front #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            req_type,
    input  logic [7:0]            value,
    output logic                  cmd_valid,
    output dq_pkg::cmd_t          cmd,
    output logic [DATA_WIDTH-1:0] cmd_data,
    input  logic                  cmd_pop
);
    import dq_pkg::*;

    cmd_t                  dec_cmd;
    logic                  accept;
    logic [1:0]            fill_reg;
    logic [1:0]            fill_next;
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    cmd_t                  q_cmd_reg  [2];
    logic [DATA_WIDTH-1:0] q_data_reg [2];

    always_comb
    begin
        dec_cmd = '{op: OP_NOP, push: 1'b0, pop: 1'b0};
        unique case (req_type)
            REQ_PUSH_FRONT: dec_cmd = '{op: OP_PUSH_FRONT, push: 1'b1, pop: 1'b0};
            REQ_PUSH_BACK:  dec_cmd = '{op: OP_PUSH_BACK,  push: 1'b1, pop: 1'b0};
            REQ_POP_FRONT:  dec_cmd = '{op: OP_POP_FRONT,  push: 1'b0, pop: 1'b1};
            REQ_POP_BACK:   dec_cmd = '{op: OP_POP_BACK,   push: 1'b0, pop: 1'b1};
            REQ_SEARCH:     dec_cmd = '{op: OP_SEARCH,     push: 1'b0, pop: 1'b0};
            REQ_CLEAR:      dec_cmd = '{op: OP_CLEAR,      push: 1'b0, pop: 1'b0};
            default:        dec_cmd = '{op: OP_NOP,        push: 1'b0, pop: 1'b0};
        endcase
    end

    assign in_stall  = fill_reg[1];
    assign accept    = in_valid && !in_stall;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_cmd_reg[rd_ptr_reg];
    assign cmd_data  = q_data_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (accept && !cmd_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!accept && cmd_pop)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // value is cut or zero-extended to the stored width here
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_cmd_reg[wr_ptr_reg]  <= dec_cmd;
            q_data_reg[wr_ptr_reg] <= DATA_WIDTH'(value);
        end
    end

endmodule

// File: rtl/core/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back
// Carries out queued commands on the ring store, scans it for a search and
// presents each result from an output register.
// ----------------------------------------------------------------------------
module dq_back #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  dq_pkg::cmd_t          cmd,
    input  logic [DATA_WIDTH-1:0] cmd_data,
    output logic                  cmd_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [4:0]            occupancy,
    output logic                  is_empty,
    output logic [7:0]            front_value,
    output logic [7:0]            back_value,
    output logic [3:0]            found_position
);
    import dq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int FW = (DATA_WIDTH > 8) ? DATA_WIDTH : 8;
    localparam int OW = (CW > 5) ? CW : 5;
    localparam int PW = (AW > 4) ? AW : 4;

    function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(CAPACITY)) ? s - SW'(CAPACITY) : s;
        return t[AW-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    bk_state_t             state_reg, state_next;
    logic [AW-1:0]         front_idx_reg, front_idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         issue_k_reg, issue_k_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_k_reg, pend_k_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [AW-1:0]         res_pos_reg, res_pos_next;
    logic                  byp_a_reg, byp_a_next;
    logic                  byp_b_reg, byp_b_next;
    logic [DATA_WIDTH-1:0] byp_data_reg;
    logic [DATA_WIDTH-1:0] rdata_a_reg;
    logic [DATA_WIDTH-1:0] rdata_b_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic [1:0]            status_reg;
    logic [4:0]            occupancy_reg;
    logic                  is_empty_reg;
    logic [7:0]            front_value_reg;
    logic [7:0]            back_value_reg;
    logic [3:0]            found_position_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr_a;
    logic [AW-1:0]         rd_addr_b;
    logic                  full;
    logic                  empty;
    logic                  hit;

    logic [DATA_WIDTH-1:0] front_data;
    logic [DATA_WIDTH-1:0] back_data;
    logic [FW-1:0]         front_ext;
    logic [FW-1:0]         back_ext;
    logic [OW-1:0]         count_ext;
    logic [PW-1:0]         pos_ext;

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);
    assign hit   = pend_reg && (rdata_a_reg == key_reg);

    assign front_data = byp_a_reg ? byp_data_reg : rdata_a_reg;
    assign back_data  = byp_b_reg ? byp_data_reg : rdata_b_reg;
    assign front_ext  = FW'(front_data);
    assign back_ext   = FW'(back_data);
    assign count_ext  = OW'(count_reg);
    assign pos_ext    = PW'(res_pos_reg);
    assign out_load   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        front_idx_next  = front_idx_reg;
        count_next      = count_reg;
        issue_k_next    = issue_k_reg;
        pend_next       = pend_reg;
        pend_k_next     = pend_k_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        byp_a_next      = 1'b0;
        byp_b_next      = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        cmd_pop         = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = front_idx_reg;
        rd_addr_a       = front_idx_reg;
        rd_addr_b       = wrap_idx(SW'(front_idx_reg) + SW'(count_reg) - SW'(1));

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    res_status_next = ST_OK;
                    res_pos_next    = '0;
                    state_next      = BK_OUT;
                    if (cmd.push && full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else if (cmd.pop && empty)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        unique case (cmd.op)
                            OP_PUSH_FRONT:
                            begin
                                front_idx_next = (front_idx_reg == '0) ?
                                                 AW'(CAPACITY - 1) : front_idx_reg - AW'(1);
                                wr_en          = 1'b1;
                                wr_addr        = front_idx_next;
                                count_next     = count_reg + CW'(1);
                            end
                            OP_PUSH_BACK:
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = wrap_idx(SW'(front_idx_reg) + SW'(count_reg));
                                count_next = count_reg + CW'(1);
                            end
                            OP_POP_FRONT:
                            begin
                                front_idx_next = wrap_idx(SW'(front_idx_reg) + SW'(1));
                                count_next     = count_reg - CW'(1);
                            end
                            OP_POP_BACK:
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            OP_SEARCH:
                            begin
                                key_next     = cmd_data;
                                issue_k_next = '0;
                                pend_next    = 1'b0;
                                if (empty)
                                begin
                                    res_status_next = ST_NOT_FOUND;
                                end
                                else
                                begin
                                    state_next = BK_SCAN;
                                end
                            end
                            OP_CLEAR:
                            begin
                                front_idx_next = '0;
                                count_next     = '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    // fetch the new ends, forwarding a write to the same entry
                    rd_addr_a  = front_idx_next;
                    rd_addr_b  = wrap_idx(SW'(front_idx_next) + SW'(count_next) - SW'(1));
                    byp_a_next = wr_en && (wr_addr == rd_addr_a);
                    byp_b_next = wr_en && (wr_addr == rd_addr_b);
                end
            end
            BK_SCAN:
            begin
                // one entry read per cycle, compared in the cycle after its read
                if (hit || (!pend_reg && (issue_k_reg == count_reg)))
                begin
                    res_status_next = hit ? ST_OK : ST_NOT_FOUND;
                    res_pos_next    = hit ? pend_k_reg : '0;
                    pend_next       = 1'b0;
                    state_next      = BK_OUT;
                end
                else if (issue_k_reg != count_reg)
                begin
                    rd_addr_a    = wrap_idx(SW'(front_idx_reg) + SW'(issue_k_reg));
                    issue_k_next = issue_k_reg + CW'(1);
                    pend_next    = 1'b1;
                    pend_k_next  = issue_k_reg[AW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            BK_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            front_idx_reg <= '0;
            count_reg     <= '0;
            issue_k_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            count_reg     <= count_next;
            issue_k_reg   <= issue_k_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_k_reg     <= pend_k_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        byp_a_reg      <= byp_a_next;
        byp_b_reg      <= byp_b_next;
        byp_data_reg   <= cmd_data;
        if ((state_reg == BK_OUT) && out_load)
        begin
            status_reg         <= res_status_reg;
            occupancy_reg      <= count_ext[4:0];
            is_empty_reg       <= empty;
            front_value_reg    <= empty ? 8'd0 : front_ext[7:0];
            back_value_reg     <= empty ? 8'd0 : back_ext[7:0];
            found_position_reg <= pos_ext[3:0];
        end
    end

    // ring store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd_data;
        end
        rdata_a_reg <= mem[rd_addr_a];
        rdata_b_reg <= mem[rd_addr_b];
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign occupancy      = occupancy_reg;
    assign is_empty       = is_empty_reg;
    assign front_value    = front_value_reg;
    assign back_value     = back_value_reg;
    assign found_position = found_position_reg;

endmodule

// File: rtl/core/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the result channel of the double-ended queue.
// ----------------------------------------------------------------------------
module dq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [4:0] occupancy,
    input logic       is_empty,
    input logic [7:0] front_value,
    input logic [7:0] back_value,
    input logic [3:0] found_position
);
    import dq_pkg::*;

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(occupancy) && $stable(front_value) && $stable(back_value))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> front_value == 8'd0 && back_value == 8'd0)
        else $error("empty result shows end values");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> is_empty)
        else $error("ignored removal on a non-empty store");

    a_pos_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_position != 4'd0 |-> status == ST_OK && !is_empty)
        else $error("position reported without a hit");

endmodule

bind double_ended_queue_with_search_core dq_checker u_dq_checker (.*);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded double-ended queue with search. A
// directed part covers the empty, full and unused-code cases. Random traffic
// then swings the store between full and empty under several sender idle and
// receiver stall patterns, including one long receiver hold-off. Each result
// transfer is checked field by field against an in-bench copy of the queue.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int DEPTH = 16;

    // request codes the block treats as no operation
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] occupancy;
        logic       is_empty;
        logic [7:0] front_value;
        logic [7:0] back_value;
        logic [3:0] found_position;
    } dq_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] req_type = '0;
    logic [7:0] value = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic [4:0] occupancy;
    logic       is_empty;
    logic [7:0] front_value;
    logic [7:0] back_value;
    logic [3:0] found_position;

    // in-bench copy of the queue
    logic [7:0] shadow_store [DEPTH];
    logic [3:0] shadow_front = '0;
    logic [4:0] shadow_count = '0;

    dq_result_t replies_due [$];
    int         fault_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         hold_request = 1'b0;
    int         hold_left = 0;

    double_ended_queue_with_search_core #(
        .CAPACITY   (DEPTH),
        .DATA_WIDTH (8)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .occupancy      (occupancy),
        .is_empty       (is_empty),
        .front_value    (front_value),
        .back_value     (back_value),
        .found_position (found_position)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // apply one request to the shadow queue and return the reply it gives
    function automatic dq_result_t deque_apply(input logic [2:0] req, input logic [7:0] val);
        dq_result_t r;
        bit         hit;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        case (req)
            REQ_PUSH_FRONT:
                if (shadow_count == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_front = shadow_front - 4'd1;
                    shadow_store[shadow_front] = val;
                    shadow_count = shadow_count + 5'd1;
                end
            REQ_PUSH_BACK:
                if (shadow_count == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_store[shadow_front + shadow_count[3:0]] = val;
                    shadow_count = shadow_count + 5'd1;
                end
            REQ_POP_FRONT:
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    shadow_front = shadow_front + 4'd1;
                    shadow_count = shadow_count - 5'd1;
                end
            REQ_POP_BACK:
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_count = shadow_count - 5'd1;
            REQ_SEARCH:
            begin
                r.status = ST_NOT_FOUND;
                for (int k = 0; k < shadow_count; k++)
                begin
                    if (!hit && shadow_store[shadow_front + 4'(k)] == val)
                    begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.found_position = 4'(k);
                    end
                end
            end
            REQ_CLEAR:
            begin
                shadow_count = '0;
                shadow_front = '0;
            end
            default: ;
        endcase
        r.occupancy = shadow_count;
        r.is_empty = (shadow_count == 0);
        if (shadow_count != 0)
        begin
            r.front_value = shadow_store[shadow_front];
            r.back_value = shadow_store[shadow_front + 4'(shadow_count - 5'd1)];
        end
        return r;
    endfunction

    // offer one request and wait for its transfer; called at a rising edge
    task automatic send_request(input logic [2:0] req, input logic [7:0] val);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        replies_due.push_back(deque_apply(req, val));
    endtask

    // sender pauses until every reply has come back
    task automatic wait_replies_done();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_cases();
        send_request(REQ_POP_FRONT, 8'h00);
        send_request(REQ_POP_BACK, 8'hFF);
        send_request(REQ_SEARCH, 8'h5A);
        send_request(REQ_UNUSED_LO, 8'hA5);
        send_request(REQ_UNUSED_HI, 8'h3C);
    endtask

    task automatic test_fill_and_reject();
        logic [7:0] v;
        for (int i = 0; i < DEPTH; i++)
        begin
            v = (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'(i * 17 + 3);
            send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, v);
        end
        send_request(REQ_PUSH_FRONT, 8'hAA);
        send_request(REQ_PUSH_BACK, 8'h55);
        // the last entry pushed at the back sits at the far end
        send_request(REQ_SEARCH, shadow_store[shadow_front + 4'd15]);
    endtask

    task automatic test_unwind();
        send_request(REQ_UNUSED_LO, 8'h00);
        send_request(REQ_POP_FRONT, 8'h00);
        send_request(REQ_POP_BACK, 8'h00);
        send_request(REQ_CLEAR, 8'hFF);
    endtask

    // random traffic that swings between filling and draining the queue
    task automatic test_random_traffic(input int items, input int idle_pct, input int stl_pct);
        int unsigned roll;
        int          tide_left;
        bit          filling;
        logic [2:0]  req;
        logic [7:0]  val;
        send_idle_pct = idle_pct;
        stall_pct = stl_pct;
        tide_left = 0;
        filling = 1'b1;
        for (int n = 0; n < items; n++)
        begin
            if (tide_left == 0)
            begin
                filling = !filling;
                tide_left = $urandom_range(20, 60);
            end
            tide_left--;
            roll = $urandom_range(99);
            val = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
            if (roll < (filling ? 55 : 20))
                req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else if (roll < (filling ? 70 : 65))
                req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
            else if (roll < 94)
            begin
                req = REQ_SEARCH;
                if (shadow_count != 0 && $urandom_range(1))
                    val = shadow_store[shadow_front + 4'($urandom_range(shadow_count - 1))];
            end
            else if (roll < 97)
                req = $urandom_range(1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
            else
                req = REQ_CLEAR;
            send_request(req, val);
        end
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b1;
        for (int n = 0; n < 24; n++)
            send_request(n[0] ? REQ_SEARCH : REQ_PUSH_BACK, 8'($urandom_range(15)));
        wait_replies_done();
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 80;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        dq_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                fault_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fault_count++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                    fault_count++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
                    fault_count++;
                end
                if (front_value !== want.front_value)
                begin
                    $error("front_value: expected %0h, got %0h", want.front_value, front_value);
                    fault_count++;
                end
                if (back_value !== want.back_value)
                begin
                    $error("back_value: expected %0h, got %0h", want.back_value, back_value);
                    fault_count++;
                end
                if (found_position !== want.found_position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, found_position);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_cases();
        test_fill_and_reject();
        test_unwind();
        test_random_traffic(340, 0, 0);
        test_backpressure();
        test_random_traffic(340, 45, 0);
        test_random_traffic(340, 0, 45);
        test_random_traffic(340, 37, 37);
        wait_replies_done();
        // a stray extra result would show up within a scan or two
        repeat (50) @(posedge clk);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/dq_pkg.sv
rtl/core/dq_front.sv
rtl/core/dq_back.sv
rtl/core/double_ended_queue_with_search_core.sv
rtl/core/dq_checker.sv
bench/tb.sv
